/* rtl/cmdl_pkg.sv */
package cmdl_pkg;

  // Width of the pending backslash run counter.
  localparam int unsigned RUN_W = 6;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;

  typedef struct packed {
    logic [7:0] char_byte;
    logic [2:0] char_length;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       arg_end;
    logic       last;
  } out_item_t;

  // Operations of the shared backslash run unit.
  typedef enum logic [2:0] {
    RUN_HOLD,
    RUN_INC,
    RUN_HALVE,
    RUN_DEC,
    RUN_CLEAR
  } run_op_t;

  // What follows the backslashes of one input byte.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_END,
    TAIL_BYTE
  } tail_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EMIT = 3'b010,
    S_TAIL = 3'b100
  } state_t;

  typedef struct packed {
    logic      fire;
    out_item_t item;
  } emit_t;

endpackage

/* rtl/cmdl_stream_if.sv */
interface cmdl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/cmdl_run_unit.sv */
module cmdl_run_unit
  import cmdl_pkg::*;
#(
  parameter int unsigned MAX_BACKSLASH_RUN = 62
) (
  input  logic             clk,
  input  logic             rst,
  input  run_op_t          op,
  output logic [RUN_W-1:0] run
);

  logic [RUN_W-1:0] run_next;

  // One counter serves both as the pending backslash run and as the
  // down counter while those backslashes are sent out.
  always_comb begin
    case (op)
      RUN_HOLD:  run_next = run;
      RUN_INC:   run_next = (run < RUN_W'(MAX_BACKSLASH_RUN)) ? run + RUN_W'(1) : run;
      RUN_HALVE: run_next = run >> 1;
      RUN_DEC:   run_next = run - RUN_W'(1);
      RUN_CLEAR: run_next = '0;
      default:   run_next = run;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else begin
      run <= run_next;
    end
  end

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    run <= RUN_W'(MAX_BACKSLASH_RUN))
    else $error("backslash run beyond its saturation limit");

endmodule

/* rtl/cmdl_ctrl.sv */
module cmdl_ctrl
  import cmdl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  in_item_t         in_data,
  output logic             in_ready,
  input  logic             slot_free,
  output emit_t            emit,
  input  logic [RUN_W-1:0] run,
  output run_op_t          run_op
);

  state_t     state, state_next;
  tail_t      tail, tail_next;
  logic [7:0] tail_byte, tail_byte_next;
  logic       in_quotes, in_quotes_next;
  logic [1:0] mb_remaining, mb_remaining_next;
  logic       after_delimiter, after_delimiter_next;
  logic       token_nonempty, token_nonempty_next;

  logic       plain, is_bs, is_quote, is_space, is_delim;
  logic       run_nz, half_nz, send_bs;
  tail_t      new_tail;
  logic [2:0] len_clamped;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    plain    = (mb_remaining == 2'd0);
    is_bs    = plain && (in_data.char_byte == CH_BACKSLASH);
    is_quote = plain && (in_data.char_byte == CH_QUOTE);
    is_space = plain && ((in_data.char_byte == CH_SPACE) || (in_data.char_byte == CH_TAB));
    is_delim = is_space && !in_quotes;
    run_nz   = (run != '0);
    half_nz  = (run[RUN_W-1:1] != '0);

    if (in_data.char_length == 3'd0) begin
      len_clamped = 3'd1;
    end else if (in_data.char_length > 3'd4) begin
      len_clamped = 3'd4;
    end else begin
      len_clamped = in_data.char_length;
    end

    state_next           = state;
    tail_next            = tail;
    tail_byte_next       = tail_byte;
    in_quotes_next       = in_quotes;
    mb_remaining_next    = mb_remaining;
    after_delimiter_next = after_delimiter;
    token_nonempty_next  = token_nonempty;
    run_op               = RUN_HOLD;
    emit                 = '0;
    send_bs              = 1'b0;
    new_tail             = TAIL_NONE;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          tail_byte_next = in_data.char_byte;
          if (in_data.end_of_line) begin
            send_bs = run_nz;
            new_tail = (token_nonempty || run_nz || in_quotes) ? TAIL_END : TAIL_NONE;
            in_quotes_next       = 1'b0;
            mb_remaining_next    = 2'd0;
            after_delimiter_next = 1'b1;
            token_nonempty_next  = 1'b0;
          end else begin
            mb_remaining_next    = plain ? 2'(len_clamped - 3'd1) : mb_remaining - 2'd1;
            after_delimiter_next = is_delim;
            if (is_delim) begin
              if (!after_delimiter) begin
                send_bs = run_nz;
                new_tail = TAIL_END;
                token_nonempty_next = 1'b0;
              end else begin
                run_op = RUN_CLEAR;
              end
            end else if (is_quote) begin
              run_op  = RUN_HALVE;
              send_bs = half_nz;
              if (!run[0]) begin
                in_quotes_next      = !in_quotes;
                token_nonempty_next = token_nonempty || half_nz;
              end else begin
                new_tail            = TAIL_BYTE;
                tail_byte_next      = CH_QUOTE;
                token_nonempty_next = 1'b1;
              end
            end else if (!is_bs) begin
              send_bs = run_nz;
              new_tail = TAIL_BYTE;
              token_nonempty_next = 1'b1;
            end else begin
              run_op = RUN_INC;
            end
          end
          tail_next = new_tail;
          if (send_bs) begin
            state_next = S_EMIT;
          end else if (new_tail != TAIL_NONE) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          emit.fire          = 1'b1;
          emit.item.out_byte = CH_BACKSLASH;
          emit.item.arg_end  = 1'b0;
          emit.item.last     = (run == RUN_W'(1)) && (tail == TAIL_NONE);
          run_op             = RUN_DEC;
          if (run == RUN_W'(1)) begin
            state_next = (tail != TAIL_NONE) ? S_TAIL : S_IDLE;
          end
        end
      end
      S_TAIL: begin
        if (slot_free) begin
          emit.fire          = 1'b1;
          emit.item.out_byte = (tail == TAIL_BYTE) ? tail_byte : 8'd0;
          emit.item.arg_end  = (tail == TAIL_END);
          emit.item.last     = 1'b1;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tail            <= TAIL_NONE;
      in_quotes       <= 1'b0;
      mb_remaining    <= 2'd0;
      after_delimiter <= 1'b1;
      token_nonempty  <= 1'b0;
    end else begin
      state           <= state_next;
      tail            <= tail_next;
      in_quotes       <= in_quotes_next;
      mb_remaining    <= mb_remaining_next;
      after_delimiter <= after_delimiter_next;
      token_nonempty  <= token_nonempty_next;
    end
  end

  always_ff @(posedge clk) begin
    tail_byte <= tail_byte_next;
  end

  a_emit_has_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (run != '0))
    else $error("backslash emission with an empty run");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (emit.fire && emit.item.last) |=> (state == S_IDLE))
    else $error("sequencer busy after the final result of a transaction");

  a_tail_known: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAIL) |-> (tail != TAIL_NONE))
    else $error("tail state entered with nothing to send");

  a_run_clear_when_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && emit.fire && (run == RUN_W'(1))) |=> (run == '0))
    else $error("backslash run not cleared after emission");

endmodule

/* rtl/command_line_argument_splitter_top.sv */
// Command-line argument splitter: one command-line byte per input transaction.
// On acceptance the sequencer state is registered, and results leave via the output register.
// A byte that causes no result leaves the sequencer idle. Any other byte keeps it busy, with no
// new byte taken, while it sends each pending backslash it releases (up to MAX_BACKSLASH_RUN,
// counted down by the shared run counter) and its tail result; a full unread output stalls it.
// Reset (rst, synchronous, active high) clears quoting, run and multibyte state and the output.
module command_line_argument_splitter_top
  import cmdl_pkg::*;
#(
  parameter int unsigned MAX_BACKSLASH_RUN = 62
) (
  input logic         clk,
  input logic         rst,
  cmdl_stream_if.sink   cmd_in,
  cmdl_stream_if.source arg_out
);

  // The block takes a new transaction only when its sequencer is idle.
  // The sequencer then emits the released backslashes one per cycle while the
  // output slot is free, and finally the tail result: the argument byte itself,
  // a literal quote or an end-of-argument marker. A backslash is held back in
  // the run counter until the next byte decides how many of them survive.

  logic             slot_free;
  emit_t            emit;
  run_op_t          run_op;
  logic [RUN_W-1:0] run;

  logic      out_valid;
  out_item_t out_data;

  // The output register frees its slot as soon as the current result is
  // taken, so a new result can be loaded in the same cycle.
  assign slot_free = !out_valid || arg_out.ready;

  cmdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in.valid),
    .in_data   (cmd_in.data),
    .in_ready  (cmd_in.ready),
    .slot_free (slot_free),
    .emit      (emit),
    .run       (run),
    .run_op    (run_op)
  );

  cmdl_run_unit #(
    .MAX_BACKSLASH_RUN (MAX_BACKSLASH_RUN)
  ) u_run_unit (
    .clk (clk),
    .rst (rst),
    .op  (run_op),
    .run (run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit.fire;
    end
  end

  // The payload needs no reset; it is only looked at while valid is high.
  always_ff @(posedge clk) begin
    if (slot_free && emit.fire) begin
      out_data <= emit.item;
    end
  end

  assign arg_out.valid = out_valid;
  assign arg_out.data  = out_data;

endmodule

/* tb/sv/command_line_argument_splitter_top_tb.sv */
module command_line_argument_splitter_top_tb
  import cmdl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The run length at which the DUT stops counting backslashes. The same value
  // is handed to the DUT and to the predictor below.
  localparam int unsigned MAX_RUN      = 62;
  // Number of randomised input transactions after the directed opening.
  localparam int unsigned RANDOM_ITEMS = 130;
  // Cycles without any transaction on either channel before the run is abandoned.
  // The longest legitimate quiet spell is the long receiver hold-off plus a
  // long gap on the sender, so this leaves a wide margin.
  localparam int unsigned IDLE_LIMIT   = 3000;
  // Length of the deliberate receiver hold-off used to back the DUT up.
  localparam int unsigned LONG_HOLD    = 400;
  // Settling time at the end: enough for a full saturated backslash flush
  // to come out, should the DUT produce anything it ought not to.
  localparam int unsigned SETTLE       = 2 * MAX_RUN + 16;

  // Predicts the argument stream and holds the results still owed by the DUT.
  // The splitting rules are kept here in the DUT's own widths: a quote flag, a
  // two-bit count of continuation bytes still due, and the pending run of
  // backslashes which is only released once the next byte tells us what it means.
  class arg_scoreboard;
    int unsigned      max_run;
    bit               quoted;
    bit [1:0]         cont_left;
    logic [RUN_W-1:0] run_len;
    bit               at_delim;
    bit               arg_has_bytes;
    out_item_t        awaited[$];
    out_item_t        batch[$];
    int               errors;

    function new(int unsigned max_run_len);
      max_run = max_run_len;
      errors  = 0;
      restart();
    endfunction

    function void restart();
      quoted        = 1'b0;
      cont_left     = '0;
      run_len       = '0;
      at_delim      = 1'b1;
      arg_has_bytes = 1'b0;
    endfunction

    function void emit(logic [7:0] b, logic is_end);
      out_item_t res;
      res.out_byte = b;
      res.arg_end  = is_end;
      res.last     = 1'b0;
      batch = {batch, res};
    endfunction

    function void emit_backslashes(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
        emit(CH_BACKSLASH, 1'b0);
        arg_has_bytes = 1'b1;
      end
    endfunction

    // Called once for every input transaction the DUT accepts.
    function void note_input(in_item_t it);
      bit          plain;
      bit          is_bs;
      bit          is_quote;
      bit          is_delim;
      int unsigned len;
      out_item_t   res;
      batch.delete();
      if (it.end_of_line) begin
        emit_backslashes(run_len);
        if (arg_has_bytes || quoted) emit(8'h00, 1'b1);
        restart();
      end else begin
        plain    = (cont_left == 2'd0);
        is_bs    = plain && (it.char_byte == CH_BACKSLASH);
        is_quote = plain && (it.char_byte == CH_QUOTE);
        is_delim = plain && !quoted &&
                   (it.char_byte == CH_SPACE || it.char_byte == CH_TAB);
        if (is_delim) begin
          if (!at_delim) begin
            emit_backslashes(run_len);
            emit(8'h00, 1'b1);
            arg_has_bytes = 1'b0;
          end
        end else if (is_quote) begin
          emit_backslashes(run_len >> 1);
          if (!run_len[0]) begin
            quoted = !quoted;
          end else begin
            emit(CH_QUOTE, 1'b0);
            arg_has_bytes = 1'b1;
          end
        end else if (!is_bs) begin
          emit_backslashes(run_len);
          emit(it.char_byte, 1'b0);
          arg_has_bytes = 1'b1;
        end
        if (!plain) begin
          cont_left = cont_left - 2'd1;
        end else begin
          len = it.char_length;
          if (len == 0) len = 1;
          if (len > 4) len = 4;
          cont_left = 2'(len - 1);
        end
        if (is_bs) begin
          if (run_len < max_run) run_len = run_len + 1'b1;
        end else begin
          run_len = '0;
        end
        at_delim = is_delim;
      end
      foreach (batch[i]) begin
        res      = batch[i];
        res.last = (i == batch.size() - 1);
        awaited  = {awaited, res};
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Called once for every output transaction the testbench takes.
    task check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result byte %02h arg_end %0b last %0b",
                         got.out_byte, got.arg_end, got.last));
      end else begin
        want = awaited.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
        if (got.arg_end !== want.arg_end)
          report($sformatf("arg_end %0b, expected %0b", got.arg_end, want.arg_end));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  cmdl_stream_if #(.payload_t(in_item_t))  cmd_in_if  ();
  cmdl_stream_if #(.payload_t(out_item_t)) arg_out_if ();

  command_line_argument_splitter_top #(
    .MAX_BACKSLASH_RUN(MAX_RUN)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_in_if),
    .arg_out (arg_out_if)
  );

  arg_scoreboard tally = new(MAX_RUN);

  // Shared between the stimulus and the receiver. The sender asks for one long
  // hold-off on the output side, and can switch its own gaps off for a while.
  bit          long_hold_req = 1'b0;
  bit          sender_calm   = 1'b0;
  bit          sat_done      = 1'b0;
  int unsigned items_sent    = 0;

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Results are taken at the rising edge, where the DUT's registered outputs
  // still hold their values from before the edge.
  always @(posedge clk) begin
    if (!rst && arg_out_if.valid && arg_out_if.ready) tally.check_result(arg_out_if.data);
  end

  // Mostly short gaps, now and then a long one. The sender has no gaps at all
  // while it is running calm.
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int unsigned receiver_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // Presents one input transaction. It is entered at a falling edge and returns
  // at the falling edge after acceptance, with valid still high; the next call
  // either changes the payload straight away or lowers valid for a gap. Each
  // falling edge therefore sees at most one update of valid.
  task automatic drive_item(input in_item_t it);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      cmd_in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_in_if.valid <= 1'b1;
    cmd_in_if.data  <= it;
    do @(posedge clk); while (!cmd_in_if.ready);
    tally.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic offer(input logic [7:0] b, input logic [2:0] len, input logic eol);
    in_item_t it;
    it.char_byte   = b;
    it.char_length = len;
    it.end_of_line = eol;
    drive_item(it);
  endtask

  // End of line, with junk in the fields that the DUT ought to ignore.
  task automatic offer_eol();
    offer(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Stops offering and waits for every outstanding result. It always waits for a
  // falling edge, so valid is never lowered and raised within one time step.
  task automatic wait_drained();
    cmd_in_if.valid <= 1'b0;
    do @(negedge clk); while (tally.pending() != 0);
  endtask

  // Length field for an ordinary single-byte character: mostly one, sometimes
  // zero, which the DUT must treat the same way.
  function automatic logic [2:0] single_len();
    return ($urandom_range(0, 7) == 0) ? 3'd0 : 3'd1;
  endfunction

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h61, 8'h7A));
      1:       return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  // Bytes that matter to the splitter turn up often; otherwise anything goes.
  function automatic logic [7:0] loaded_byte();
    case ($urandom_range(0, 7))
      0:       return CH_BACKSLASH;
      1:       return CH_QUOTE;
      2:       return CH_SPACE;
      3:       return CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_delims(input int unsigned n);
    repeat (n) offer($urandom_range(0, 1) ? CH_SPACE : CH_TAB, single_len(), 1'b0);
  endtask

  task automatic send_word();
    repeat ($urandom_range(1, 4)) offer(word_byte(), single_len(), 1'b0);
  endtask

  // A quoted section, possibly with blanks inside and now and then left open.
  task automatic send_quoted();
    offer(CH_QUOTE, single_len(), 1'b0);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) send_delims(1);
      else offer(word_byte(), single_len(), 1'b0);
    end
    if ($urandom_range(0, 4) != 0) offer(CH_QUOTE, single_len(), 1'b0);
  endtask

  // A run of backslashes, followed by a quote, a word byte or whatever comes
  // next. The first run of the random part goes past saturation, and a few
  // later ones do too.
  task automatic send_backslashes();
    int unsigned n;
    if (!sat_done || $urandom_range(0, 29) == 0) begin
      n        = $urandom_range(MAX_RUN + 1, MAX_RUN + 8);
      sat_done = 1'b1;
    end else begin
      n = $urandom_range(1, 5);
    end
    repeat (n) offer(CH_BACKSLASH, single_len(), 1'b0);
    case ($urandom_range(0, 2))
      0: offer(CH_QUOTE, single_len(), 1'b0);
      1: offer(word_byte(), single_len(), 1'b0);
      default: ;
    endcase
  endtask

  // A multibyte character whose continuation bytes often look like specials.
  // Their length fields carry junk, which the DUT must ignore.
  task automatic send_multibyte();
    int unsigned len;
    len = $urandom_range(2, 4);
    offer({1'b1, 7'($urandom)}, 3'(len), 1'b0);
    repeat (len - 1) offer(loaded_byte(), 3'($urandom_range(0, 7)), 1'b0);
  endtask

  // A well-formed command line with random content, closed by an end of line.
  task automatic send_line();
    repeat ($urandom_range(1, 4)) begin
      send_delims($urandom_range(0, 3));
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0: send_word();
          1: send_quoted();
          2: send_backslashes();
          default: send_multibyte();
        endcase
      end
    end
    send_delims($urandom_range(0, 2));
    offer_eol();
  endtask

  // Unstructured bytes with any length field; may leave a line half finished.
  task automatic send_noise();
    repeat ($urandom_range(3, 12)) begin
      if ($urandom_range(0, 9) == 0) offer_eol();
      else offer(loaded_byte(), 3'($urandom_range(0, 7)), 1'b0);
    end
  endtask

  // Receiver: takes results with random gaps and occasional runs of steady
  // readiness. On request it holds off for a long stretch so that the DUT
  // backs up and stops accepting input.
  initial begin : receiver
    int unsigned hold;
    int unsigned span;
    int unsigned calm_left;
    arg_out_if.ready = 1'b0;
    calm_left        = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (calm_left > 0) begin
        hold = 0;
      end else begin
        hold = receiver_gap();
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
      end
      if (hold > 0) begin
        arg_out_if.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      arg_out_if.ready <= 1'b1;
      span = $urandom_range(1, 6);
      repeat (span) @(negedge clk);
      calm_left = (calm_left > span) ? calm_left - span : 0;
    end
  end

  // Watchdog: ends the run if neither channel moves a transaction for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_in_if.valid && cmd_in_if.ready) || (arg_out_if.valid && arg_out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("command_line_argument_splitter_top verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned line_no;
    int unsigned random_start;
    cmd_in_if.valid = 1'b0;
    cmd_in_if.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening. A delimiter at the very start produces nothing, since
    // the start of the line already counts as one.
    offer(CH_SPACE, 3'd1, 1'b0);
    // A length field of zero behaves as one.
    offer(8'h61, 3'd0, 1'b0);
    // A tab closes the argument; a second one is absorbed.
    offer(CH_TAB, 3'd1, 1'b0);
    offer(CH_TAB, 3'd1, 1'b0);
    // An empty quoted pair followed by a blank still yields an end marker.
    offer(CH_QUOTE, 3'd1, 1'b0);
    offer(CH_QUOTE, 3'd1, 1'b0);
    offer(CH_SPACE, 3'd1, 1'b0);
    // Three backslashes and a quote: one backslash and a literal quote.
    repeat (3) offer(CH_BACKSLASH, 3'd1, 1'b0);
    offer(CH_QUOTE, 3'd1, 1'b0);
    // Two backslashes and a quote: one backslash, and quoting opens.
    repeat (2) offer(CH_BACKSLASH, 3'd1, 1'b0);
    offer(CH_QUOTE, 3'd1, 1'b0);
    // A blank inside quotes is part of the argument.
    offer(CH_SPACE, 3'd1, 1'b0);
    // A length field above four behaves as four; the three continuation
    // bytes are specials that must pass through literally.
    offer(8'hE3, 3'd7, 1'b0);
    offer(CH_BACKSLASH, 3'd7, 1'b0);
    offer(CH_QUOTE, 3'd0, 1'b0);
    offer(CH_TAB, 3'd2, 1'b0);
    // Quoting closes; then backslashes before a blank are released, not lost.
    offer(CH_QUOTE, 3'd1, 1'b0);
    repeat (2) offer(CH_BACKSLASH, 3'd1, 1'b0);
    offer(CH_SPACE, 3'd1, 1'b0);
    // Extreme byte values, then an end of line with all-ones junk fields.
    offer(8'hFF, 3'd1, 1'b0);
    offer(8'h00, 3'd1, 1'b0);
    offer(8'hFF, 3'd7, 1'b1);
    // An end of line on an empty line produces nothing.
    offer(8'h00, 3'd0, 1'b1);
    // A quote left open at the end of the line still closes an argument.
    offer(CH_QUOTE, 3'd1, 1'b0);
    offer(8'h00, 3'd0, 1'b1);

    // Random part: mostly well-formed lines, some noise once the pressure
    // scenarios are done. The second line starts only after every result is
    // in; the third is offered flat out while the receiver holds off.
    line_no      = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      sender_calm = ($urandom_range(0, 5) == 0);
      if (line_no == 1) wait_drained();
      if (line_no == 2) begin
        long_hold_req = 1'b1;
        sender_calm   = 1'b1;
      end
      if (line_no >= 3 && $urandom_range(0, 4) == 0) send_noise();
      else send_line();
      line_no++;
    end
    sender_calm = 1'b0;

    wait_drained();
    // Any stray result still coming out is caught by the monitor meanwhile.
    repeat (SETTLE) @(negedge clk);
    if (tally.errors == 0) begin
      $display("command_line_argument_splitter_top verification clean");
    end else begin
      $display("command_line_argument_splitter_top verification failed");
    end
    $finish;
  end

endmodule

/* command_line_argument_splitter_top.f */
rtl/cmdl_pkg.sv
rtl/cmdl_stream_if.sv
rtl/cmdl_run_unit.sv
rtl/cmdl_ctrl.sv
rtl/command_line_argument_splitter_top.sv
tb/sv/command_line_argument_splitter_top_tb.sv
